### rtl/brd_pkg.sv
package brd_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 7;
  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 7;

  localparam logic [OP_W-1:0] OP_PUSH_BACK    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP          = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT   = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_BACK    = 3'd3;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd4;
  localparam logic [OP_W-1:0] OP_PUSH_BACK_NR = 3'd5;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT_NR = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_DUP   = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
  } ctrl_cmd_t;

  // zero reads as one slot, anything above the storage reads as all of it
  function automatic logic [CNT_W-1:0] cap_clamp(input logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

endpackage

### rtl/brd_if.sv
interface brd_req_if;
  import brd_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [BYTE_W-1:0]   data_in;
  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface brd_rsp_if;
  import brd_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   data_out;
  logic [ST_W-1:0]     status;
  logic [OCC_W-1:0]    occupancy;
  modport source (output valid, output data_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input data_out, input status, input occupancy,
                  output ready);
endinterface

interface brd_cfg_if;
  import brd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CAP_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/byte_ring_deque_top.sv
// Byte deque on a ring of 64 one-byte slots, of which the capacity register
// selects how many are in use (0 reads as 1). Requests push at either end,
// pop or peek the front, or peek the back; the no-repeat pushes refuse a
// byte equal to the end they push to. Every request returns one response
// with the byte read (zero for pushes and empty status), a status and the
// occupancy after the request. The request passes a registered read of the
// slot memory, then a step that updates the pointers and writes the slot;
// the response is then valid and held until taken. The next request is
// accepted in the cycle after it is taken, so no new request is taken before
// the last response. A capacity write empties the queue and is taken at any
// time; issue it only while no request is open.
module byte_ring_deque_top (
  input  logic      clk,
  input  logic      rst,
  brd_req_if.sink   req,
  brd_rsp_if.source rsp,
  brd_cfg_if.sink   cfg
);
  import brd_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg.ready = 1'b1;

  brd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  brd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .opcode    (req.opcode),
    .data_in   (req.data_in),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.data),
    .data_out  (rsp.data_out),
    .status    (rsp.status),
    .occupancy (rsp.occupancy)
  );

endmodule

### rtl/brd_ctrl.sv
module brd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output brd_pkg::ctrl_cmd_t cmd
);
  import brd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_RESP} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_READ;
            in_ready <= 1'b0;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          state     <= S_RESP;
          out_valid <= 1'b1;
        end
        S_RESP: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
          in_ready  <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.read    = (state == S_READ);
    cmd.exec    = (state == S_EXEC);
  end

endmodule

### rtl/brd_datapath.sv
module brd_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  brd_pkg::ctrl_cmd_t        cmd,
  input  logic [brd_pkg::OP_W-1:0]  opcode,
  input  logic [brd_pkg::BYTE_W-1:0] data_in,
  input  logic                      cfg_we,
  input  logic [brd_pkg::CAP_W-1:0] cfg_data,
  output logic [brd_pkg::BYTE_W-1:0] data_out,
  output logic [brd_pkg::ST_W-1:0]  status,
  output logic [brd_pkg::OCC_W-1:0] occupancy
);
  import brd_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] din;

  logic [IDX_W-1:0]  cap_m1;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  fill;

  logic [IDX_W-1:0]  head_next;
  logic [IDX_W-1:0]  tail_next;
  logic [CNT_W-1:0]  fill_next;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  head_dec;
  logic [IDX_W-1:0]  tail_inc;
  logic [IDX_W-1:0]  tail_dec;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic [BYTE_W-1:0] dout_next;
  logic [ST_W-1:0]   st_next;
  logic              full;
  logic              empty;
  logic              do_back;
  logic              do_front;

  always_comb begin
    head_inc = (head == cap_m1) ? '0 : head + IDX_W'(1);
    tail_inc = (tail == cap_m1) ? '0 : tail + IDX_W'(1);
    head_dec = (head == '0 || head > cap_m1) ? cap_m1 : head - IDX_W'(1);
    tail_dec = (tail == '0 || tail > cap_m1) ? cap_m1 : tail - IDX_W'(1);
    full     = (fill >= CNT_W'(cap_m1) + CNT_W'(1));
    empty    = (fill == '0);
    rd_addr  = (op == OP_PEEK_BACK || op == OP_PUSH_BACK_NR) ? tail_dec : head;
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= opcode;
      din <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= din;
    end
  end

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    dout_next = '0;
    st_next   = ST_OK;
    do_back   = 1'b0;
    do_front  = 1'b0;
    case (op)
      OP_PUSH_BACK:  do_back = 1'b1;
      OP_PUSH_FRONT: do_front = 1'b1;
      OP_POP: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          dout_next = rd_data;
          head_next = head_inc;
          fill_next = fill - CNT_W'(1);
        end
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (empty) st_next = ST_EMPTY;
        else dout_next = rd_data;
      end
      OP_PUSH_BACK_NR: begin
        if (!empty && rd_data == din) st_next = ST_DUP;
        else do_back = 1'b1;
      end
      OP_PUSH_FRONT_NR: begin
        if (empty) do_back = 1'b1;
        else if (rd_data == din) st_next = ST_DUP;
        else do_front = 1'b1;
      end
      default: ;
    endcase
    wr_en   = 1'b0;
    wr_addr = tail;
    if (do_back || do_front) begin
      if (full) begin
        st_next = ST_FULL;
      end else begin
        fill_next = fill + CNT_W'(1);
        wr_en     = cmd.exec;
        if (do_back) begin
          tail_next = tail_inc;
        end else begin
          wr_addr   = head_dec;
          head_next = head_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_m1 <= IDX_W'(cap_clamp(CAP_RESET) - CNT_W'(1));
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
    end else if (cfg_we) begin
      cap_m1 <= IDX_W'(cap_clamp(cfg_data) - CNT_W'(1));
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      data_out  <= dout_next;
      status    <= st_next;
      occupancy <= OCC_W'(fill_next);
    end
  end

endmodule

### rtl/brd_checker.sv
module brd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [brd_pkg::BYTE_W-1:0] data_out,
  input logic [brd_pkg::ST_W-1:0]  status,
  input logic [brd_pkg::OCC_W-1:0] occupancy
);
  import brd_pkg::*;

  // one request open at a time
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
    else $error("request accepted while another is open");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(occupancy) <= DEPTH))
    else $error("occupancy beyond storage");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_EMPTY) |-> (occupancy == '0 && data_out == '0))
    else $error("empty status with data or occupancy");

  a_reject_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_FULL || status == ST_DUP)) |->
      (data_out == '0 && occupancy != '0))
    else $error("rejected push with data or empty queue");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(data_out) &&
      $stable(status) && $stable(occupancy)))
    else $error("stalled response changed");

endmodule

bind byte_ring_deque_top brd_checker u_brd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .data_out  (rsp.data_out),
  .status    (rsp.status),
  .occupancy (rsp.occupancy)
);
